// ----- rtl/kwm_pkg.sv -----
package kwm_pkg;

  localparam int LISTS_DEF          = 16;
  localparam int ELEMS_PER_LIST_DEF = 64;
  localparam int DATA_WIDTH_DEF     = 32;

  localparam int KIND_W    = 2;
  localparam int LIST_ID_W = 4;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;

  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // control from the scan sequencer to the minimum tracker
  typedef struct packed {
    logic start;
    logic cand_valid;
  } kwm_trk_ctl_t;

endpackage

// ----- rtl/kwm_min_track.sv -----
module kwm_min_track
  import kwm_pkg::*;
#(
  parameter int LW = 4,
  parameter int CW = 7,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  kwm_trk_ctl_t  ctl,
  input  logic [LW-1:0] cand_list,
  input  logic [CW-1:0] cand_rp,
  input  logic [CW-1:0] cand_wc,
  input  logic [DW-1:0] cand_data,
  output logic          found,
  output logic [LW-1:0] best_list,
  output logic [CW-1:0] best_rp,
  output logic [CW-1:0] best_wc,
  output logic [DW-1:0] best_data
);

  logic          found_r;
  logic [LW-1:0] best_list_r;
  logic [CW-1:0] best_rp_r;
  logic [CW-1:0] best_wc_r;
  logic [DW-1:0] best_data_r;
  logic          take;

  // strictly smaller only: lists arrive in ascending order, so ties keep the lower list
  assign take = ctl.cand_valid && !ctl.start &&
                (!found_r || ($signed(cand_data) < $signed(best_data_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.start) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_list_r <= cand_list;
      best_rp_r   <= cand_rp;
      best_wc_r   <= cand_wc;
      best_data_r <= cand_data;
    end
  end

  assign found     = found_r;
  assign best_list = best_list_r;
  assign best_rp   = best_rp_r;
  assign best_wc   = best_wc_r;
  assign best_data = best_data_r;

endmodule

// ----- rtl/k_way_sorted_merge_unit.sv -----
// channel | ports                                        | direction
// --------+----------------------------------------------+----------
// input   | in_valid, in_ready, in_kind, in_list_id,      | into block
//         | in_value                                     |
// result  | out_valid, out_ready, out_status,             | out of block
//         | out_merged_value                             |
//
// One item at a time. An append reads the list's head entry, then writes the element and
// the head back; a clear sweeps and zeroes the head-pointer memory; a pop walks the
// head-pointer memory one list per cycle through its single read port, the element memory
// read trailing in the cycle after, and the minimum is tracked. After reset a sweep zeroes
// the head-pointer memory before the first item is taken. A waiting result sits in the
// output register while the next item is accepted and worked on.
module k_way_sorted_merge_unit
  import kwm_pkg::*;
#(
  parameter int LISTS          = LISTS_DEF,
  parameter int ELEMS_PER_LIST = ELEMS_PER_LIST_DEF,
  parameter int DATA_WIDTH     = DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [KIND_W-1:0]          in_kind,
  input  logic [LIST_ID_W-1:0]       in_list_id,
  input  logic signed [VALUE_W-1:0]  in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [VALUE_W-1:0]  out_merged_value
);

  localparam int LW    = $clog2(LISTS);
  localparam int CW    = $clog2(ELEMS_PER_LIST + 1);
  localparam int HW    = 2 * CW;
  localparam int DW    = DATA_WIDTH;
  localparam int DEPTH = LISTS * ELEMS_PER_LIST;
  localparam int EAW   = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_APP, S_SCAN, S_DRAIN1, S_DRAIN2, S_WB, S_CLR, S_RESP
  } state_t;

  function automatic logic [EAW-1:0] elem_addr(input logic [LW-1:0] l,
                                               input logic [CW-1:0] p);
    return EAW'(l) * EAW'(ELEMS_PER_LIST) + EAW'(p);
  endfunction

  // memories: per-list {write_count, read_position}, and the elements
  logic [HW-1:0] head_mem [LISTS];
  logic [DW-1:0] elem_mem [DEPTH];

  state_t        state_r;
  logic [LW-1:0] sweep_idx_r;
  logic [LW-1:0] app_list_r;
  logic [DW-1:0] app_value_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [VALUE_W-1:0]  res_value_r;
  logic          out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [VALUE_W-1:0]  out_value_r;

  logic          s1_valid_r;
  logic [LW-1:0] s1_list_r;
  logic          s2_valid_r;
  logic [LW-1:0] s2_list_r;
  logic [CW-1:0] s2_rp_r;
  logic [CW-1:0] s2_wc_r;

  logic          hm_re, hm_we;
  logic [LW-1:0] hm_ra, hm_wa;
  logic [HW-1:0] hm_wd, hm_rd_r;
  logic          em_re, em_we;
  logic [EAW-1:0] em_ra, em_wa;
  logic [DW-1:0] em_wd, em_rd_r;

  logic [CW-1:0] hd_wc, hd_rp;
  logic          hd_nonempty, hd_full;
  logic          last_idx;
  logic          in_acc;
  logic [LW+3:0] lid_ext;
  logic          lid_ok;
  logic [LW-1:0] lid_idx;
  logic [63:0]   value_ext;
  logic [DW+31:0] best_wide;

  kwm_trk_ctl_t  trk_ctl;
  logic          trk_found;
  logic [LW-1:0] trk_list;
  logic [CW-1:0] trk_rp, trk_wc;
  logic [DW-1:0] trk_data;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign lid_ext   = {{LW{1'b0}}, in_list_id};
  assign lid_ok    = lid_ext < (LW+4)'(LISTS);
  assign lid_idx   = lid_ext[LW-1:0];
  assign value_ext = {{32{in_value[VALUE_W-1]}}, in_value};

  assign hd_wc       = hm_rd_r[HW-1:CW];
  assign hd_rp       = hm_rd_r[CW-1:0];
  assign hd_nonempty = hd_rp < hd_wc;
  assign hd_full     = hd_wc >= CW'(ELEMS_PER_LIST);
  assign last_idx    = (sweep_idx_r == LW'(LISTS - 1));
  assign best_wide   = {32'b0, trk_data};

  always_comb begin
    hm_re = 1'b0;
    hm_ra = sweep_idx_r;
    hm_we = 1'b0;
    hm_wa = sweep_idx_r;
    hm_wd = '0;
    em_we = 1'b0;
    em_wa = elem_addr(app_list_r, hd_wc);
    em_wd = app_value_r;
    if (state_r == S_IDLE && in_valid && in_kind == KIND_APPEND && lid_ok) begin
      hm_re = 1'b1;
      hm_ra = lid_idx;
    end
    if (state_r == S_SCAN) begin
      hm_re = 1'b1;
    end
    case (state_r)
      S_INIT, S_CLR: begin
        hm_we = 1'b1;
      end
      S_APP: begin
        if (!hd_full) begin
          hm_we = 1'b1;
          hm_wa = app_list_r;
          hm_wd = {hd_wc + CW'(1), hd_rp};
          em_we = 1'b1;
        end
      end
      S_WB: begin
        if (trk_found) begin
          hm_we = 1'b1;
          hm_wa = trk_list;
          hm_wd = {trk_wc, trk_rp + CW'(1)};
        end
      end
      default: begin
      end
    endcase
  end

  // element read is issued in the cycle after the head read
  assign em_re = s1_valid_r && hd_nonempty;
  assign em_ra = elem_addr(s1_list_r, hd_rp);

  always_ff @(posedge clk) begin
    if (hm_we) begin
      head_mem[hm_wa] <= hm_wd;
    end
    if (hm_re) begin
      hm_rd_r <= head_mem[hm_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (em_we) begin
      elem_mem[em_wa] <= em_wd;
    end
    if (em_re) begin
      em_rd_r <= elem_mem[em_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= (state_r == S_SCAN);
      s2_valid_r <= s1_valid_r && hd_nonempty;
    end
  end

  always_ff @(posedge clk) begin
    s1_list_r <= sweep_idx_r;
    s2_list_r <= s1_list_r;
    s2_rp_r   <= hd_rp;
    s2_wc_r   <= hd_wc;
  end

  assign trk_ctl.start      = in_acc && (in_kind == KIND_POP);
  assign trk_ctl.cand_valid = s2_valid_r;

  kwm_min_track #(
    .LW (LW),
    .CW (CW),
    .DW (DW)
  ) u_min_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (trk_ctl),
    .cand_list (s2_list_r),
    .cand_rp   (s2_rp_r),
    .cand_wc   (s2_wc_r),
    .cand_data (em_rd_r),
    .found     (trk_found),
    .best_list (trk_list),
    .best_rp   (trk_rp),
    .best_wc   (trk_wc),
    .best_data (trk_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sweep_idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the response state reloads the output register itself
      if (out_valid_r && out_ready && state_r != S_RESP) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_INIT: begin
          if (last_idx) begin
            sweep_idx_r <= '0;
            state_r     <= S_IDLE;
          end else begin
            sweep_idx_r <= sweep_idx_r + LW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            sweep_idx_r <= '0;
            case (in_kind)
              KIND_APPEND: begin
                app_list_r  <= lid_idx;
                app_value_r <= value_ext[DW-1:0];
                if (lid_ok) begin
                  state_r <= S_APP;
                end else begin
                  res_status_r <= STATUS_FULL;
                  res_value_r  <= '0;
                  state_r      <= S_RESP;
                end
              end
              KIND_POP: begin
                state_r <= S_SCAN;
              end
              KIND_CLEAR: begin
                state_r <= S_CLR;
              end
              default: begin
                res_status_r <= STATUS_OK;
                res_value_r  <= '0;
                state_r      <= S_RESP;
              end
            endcase
          end
        end
        S_APP: begin
          res_status_r <= hd_full ? STATUS_FULL : STATUS_OK;
          res_value_r  <= '0;
          state_r      <= S_RESP;
        end
        S_SCAN: begin
          if (last_idx) begin
            sweep_idx_r <= '0;
            state_r     <= S_DRAIN1;
          end else begin
            sweep_idx_r <= sweep_idx_r + LW'(1);
          end
        end
        S_DRAIN1: begin
          state_r <= S_DRAIN2;
        end
        S_DRAIN2: begin
          state_r <= S_WB;
        end
        S_WB: begin
          res_status_r <= trk_found ? STATUS_OK : STATUS_EMPTY;
          res_value_r  <= trk_found ? best_wide[VALUE_W-1:0] : '0;
          state_r      <= S_RESP;
        end
        S_CLR: begin
          if (last_idx) begin
            sweep_idx_r  <= '0;
            res_status_r <= STATUS_OK;
            res_value_r  <= '0;
            state_r      <= S_RESP;
          end else begin
            sweep_idx_r <= sweep_idx_r + LW'(1);
          end
        end
        S_RESP: begin
          // hold until the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_value_r  <= res_value_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_merged_value = $signed(out_value_r);

endmodule

// ----- test/k_way_sorted_merge_unit_tb.sv -----
module k_way_sorted_merge_unit_tb
  import kwm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LISTS        = LISTS_DEF;
  localparam int ELEMS        = ELEMS_PER_LIST_DEF;
  localparam int ITEMS        = 1300;
  localparam int TAIL_ITEMS   = 200;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 2 * (LISTS + 5) + 10;

  // the block never defines this code; it must answer ok with a zero value
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] merged;
  } merge_result_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [LIST_ID_W-1:0] list_id;
    logic [VALUE_W-1:0]   value;
    logic [6:0]           reps;
    logic                 typed;
    logic [STATUS_W-1:0]  status;
    logic [VALUE_W-1:0]   merged;
  } opening_row_t;

  // reps > 1 appends value, value+1, ... to the same list
  localparam opening_row_t OPENING_ITEMS [0:24] = '{
    '{KIND_POP,    4'd0,  32'h0000_0000, 7'd1,  1'b1, STATUS_EMPTY, 32'h0000_0000},
    '{KIND_CLEAR,  4'd0,  32'h0000_0000, 7'd1,  1'b1, STATUS_OK,    32'h0000_0000},
    '{KIND_UNUSED, 4'd15, 32'hFFFF_FFFF, 7'd1,  1'b1, STATUS_OK,    32'h0000_0000},
    '{KIND_APPEND, 4'd0,  32'h8000_0000, 7'd1,  1'b1, STATUS_OK,    32'h0000_0000},
    '{KIND_APPEND, 4'd15, 32'h7FFF_FFFF, 7'd1,  1'b1, STATUS_OK,    32'h0000_0000},
    '{KIND_APPEND, 4'd7,  32'hFFFF_FFFF, 7'd1,  1'b1, STATUS_OK,    32'h0000_0000},
    '{KIND_APPEND, 4'd3,  32'hFFFF_FFFF, 7'd1,  1'b1, STATUS_OK,    32'h0000_0000},
    '{KIND_APPEND, 4'd7,  32'h0000_0000, 7'd1,  1'b1, STATUS_OK,    32'h0000_0000},
    '{KIND_POP,    4'd0,  32'h0000_0000, 7'd1,  1'b1, STATUS_OK,    32'h8000_0000},
    '{KIND_POP,    4'd15, 32'hFFFF_FFFF, 7'd1,  1'b0, STATUS_OK,    32'h0000_0000},
    '{KIND_POP,    4'd0,  32'h0000_0000, 7'd1,  1'b0, STATUS_OK,    32'h0000_0000},
    '{KIND_POP,    4'd0,  32'h0000_0000, 7'd1,  1'b0, STATUS_OK,    32'h0000_0000},
    '{KIND_POP,    4'd0,  32'h0000_0000, 7'd1,  1'b0, STATUS_OK,    32'h0000_0000},
    '{KIND_POP,    4'd0,  32'h0000_0000, 7'd1,  1'b1, STATUS_EMPTY, 32'h0000_0000},
    '{KIND_APPEND, 4'd10, 32'h0000_0010, 7'd64, 1'b0, STATUS_OK,    32'h0000_0000},
    '{KIND_APPEND, 4'd10, 32'h0000_1234, 7'd1,  1'b1, STATUS_FULL,  32'h0000_0000},
    '{KIND_POP,    4'd0,  32'h0000_0000, 7'd1,  1'b0, STATUS_OK,    32'h0000_0000},
    '{KIND_APPEND, 4'd10, 32'h0000_5678, 7'd1,  1'b1, STATUS_FULL,  32'h0000_0000},
    '{KIND_APPEND, 4'd2,  32'h0000_0064, 7'd1,  1'b0, STATUS_OK,    32'h0000_0000},
    '{KIND_APPEND, 4'd2,  32'hFFFF_FF9C, 7'd1,  1'b0, STATUS_OK,    32'h0000_0000},
    '{KIND_POP,    4'd0,  32'h0000_0000, 7'd1,  1'b0, STATUS_OK,    32'h0000_0000},
    '{KIND_CLEAR,  4'd9,  32'h5555_AAAA, 7'd1,  1'b1, STATUS_OK,    32'h0000_0000},
    '{KIND_POP,    4'd0,  32'h0000_0000, 7'd1,  1'b1, STATUS_EMPTY, 32'h0000_0000},
    '{KIND_APPEND, 4'd10, 32'h0000_0005, 7'd1,  1'b1, STATUS_OK,    32'h0000_0000},
    '{KIND_POP,    4'd0,  32'h0000_0000, 7'd1,  1'b1, STATUS_OK,    32'h0000_0005}
  };

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [KIND_W-1:0]          in_kind;
  logic [LIST_ID_W-1:0]       in_list_id;
  logic signed [VALUE_W-1:0]  in_value;
  logic                       out_valid;
  logic                       out_ready;
  logic [STATUS_W-1:0]        out_status;
  logic signed [VALUE_W-1:0]  out_merged_value;

  // predictor state: one region per list, tail and head counters
  logic signed [VALUE_W-1:0] list_mem [LISTS][ELEMS];
  int unsigned               tail_cnt [LISTS];
  int unsigned               head_pos [LISTS];

  merge_result_t pending_results [$];
  int            items_sent   = 0;
  int            mismatch_cnt = 0;
  bit            tail_phase   = 1'b0;
  bit            hold_long    = 1'b0;

  k_way_sorted_merge_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_list_id       (in_list_id),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_merged_value (out_merged_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic predict_merge(input logic [KIND_W-1:0] kind,
                               input logic [LIST_ID_W-1:0] lid,
                               input logic signed [VALUE_W-1:0] val,
                               output merge_result_t res);
    int best;
    best       = -1;
    res.status = STATUS_OK;
    res.merged = '0;
    case (kind)
      KIND_APPEND: begin
        if (tail_cnt[lid] >= ELEMS) begin
          res.status = STATUS_FULL;
        end else begin
          list_mem[lid][tail_cnt[lid]] = val;
          tail_cnt[lid]++;
        end
      end
      KIND_POP: begin
        for (int i = 0; i < LISTS; i++) begin
          if (head_pos[i] < tail_cnt[i]) begin
            if (best < 0 || list_mem[i][head_pos[i]] < list_mem[best][head_pos[best]])
              best = i;
          end
        end
        if (best < 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.merged = list_mem[best][head_pos[best]];
          head_pos[best]++;
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < LISTS; i++) begin
          tail_cnt[i] = 0;
          head_pos[i] = 0;
        end
      end
      default: ;
    endcase
  endtask

  // offer one item, hold it until taken, then maybe idle for a burst
  task automatic send_item(input logic [KIND_W-1:0] kind,
                           input logic [LIST_ID_W-1:0] lid,
                           input logic [VALUE_W-1:0] val,
                           input bit typed,
                           input merge_result_t typed_res);
    merge_result_t res;
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_list_id <= lid;
    in_value   <= val;
    do @(posedge clk); while (!in_ready);
    predict_merge(kind, lid, val, res);
    pending_results.push_back(typed ? typed_res : res);
    if (kind != KIND_UNUSED)
      items_sent++;
    if (!tail_phase && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic send_pop();
    send_item(KIND_POP, LIST_ID_W'($urandom), $urandom, 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ascending values per list over a random set of lists, then pops and a possible clear
  task automatic sorted_run();
    logic signed [VALUE_W-1:0] next_val [LISTS];
    logic [LIST_ID_W-1:0]      first_lid;
    logic [LIST_ID_W-1:0]      lid;
    int                        n_lists;
    int                        n_app;
    int                        n_pop;
    int                        mode;
    int unsigned               step_max;
    mode      = $urandom_range(0, 2);
    n_lists   = $urandom_range(1, LISTS);
    n_app     = $urandom_range(1, 48);
    first_lid = LIST_ID_W'($urandom);
    step_max  = (mode == 0) ? 2 : (mode == 1) ? 5000 : 32'h0400_0000;
    for (int i = 0; i < LISTS; i++)
      next_val[i] = (mode == 2) ? (32'h8000_0000 + $urandom_range(0, 255)) : $urandom;
    for (int i = 0; i < n_app; i++) begin
      lid = first_lid + LIST_ID_W'($urandom_range(0, n_lists - 1));
      send_item(KIND_APPEND, lid, next_val[lid], 1'b0, '0);
      next_val[lid] = next_val[lid] + $urandom_range(0, step_max);
      if ($urandom_range(0, 5) == 0)
        send_pop();
    end
    n_pop = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n_app)
                                        : n_app + $urandom_range(0, 2);
    repeat (n_pop) send_pop();
    if ($urandom_range(0, 1) == 0)
      send_item(KIND_CLEAR, LIST_ID_W'($urandom), $urandom, 1'b0, '0);
  endtask

  // overrun one list, pop a few, show popping frees no space
  task automatic fill_run();
    logic [LIST_ID_W-1:0]      lid;
    logic signed [VALUE_W-1:0] v;
    lid = LIST_ID_W'($urandom);
    v   = $urandom;
    send_item(KIND_CLEAR, LIST_ID_W'($urandom), $urandom, 1'b0, '0);
    repeat (ELEMS + $urandom_range(1, 4)) begin
      send_item(KIND_APPEND, lid, v, 1'b0, '0);
      v = v + $urandom_range(0, 3);
    end
    repeat ($urandom_range(1, 8)) send_pop();
    send_item(KIND_APPEND, lid, v, 1'b0, '0);
  endtask

  task automatic noise_run();
    repeat ($urandom_range(8, 20))
      send_item(KIND_W'($urandom_range(0, 3)), LIST_ID_W'($urandom), $urandom, 1'b0, '0);
  endtask

  initial begin : stimulus
    merge_result_t typed_res;
    int            pick;
    bit            hold_done;
    bit            pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_kind    = KIND_APPEND;
    in_list_id = '0;
    in_value   = '0;
    for (int i = 0; i < LISTS; i++) begin
      tail_cnt[i] = 0;
      head_pos[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (OPENING_ITEMS[r]) begin
      typed_res.status = OPENING_ITEMS[r].status;
      typed_res.merged = OPENING_ITEMS[r].merged;
      for (int k = 0; k < OPENING_ITEMS[r].reps; k++)
        send_item(OPENING_ITEMS[r].kind, OPENING_ITEMS[r].list_id,
                  OPENING_ITEMS[r].value + VALUE_W'(k), OPENING_ITEMS[r].typed, typed_res);
    end

    while (items_sent < ITEMS) begin
      if (items_sent >= ITEMS - TAIL_ITEMS)
        tail_phase = 1'b1;
      if (!hold_done && items_sent > 400) begin
        hold_long = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && items_sent > 800) begin
        wait_drained();
        pause_done = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick < 7)
        sorted_run();
      else if (pick < 8)
        fill_run();
      else
        noise_run();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin : sink
    out_ready = 1'b0;
    forever begin
      if (hold_long) begin
        // hold off long enough for the block to back up into its input
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
      end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 60)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    merge_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: status %0d, merged_value %0d",
               out_status, out_merged_value);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          mismatch_cnt++;
        end
        if (out_merged_value !== want.merged) begin
          $error("merged_value: expected %0d, actual %0d", want.merged, out_merged_value);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
